FILE: rtl/core/gcm_pkg.sv
// Package: constants, types and codes of the gamma coincidence matrix unit.
package gcm_pkg;

  localparam int MAX_HITS   = 64;
  localparam int HIT_IDX_W  = $clog2(MAX_HITS);
  localparam int KEPT_CNT_W = $clog2(MAX_HITS + 1);
  localparam int BINS       = 2048;
  localparam int BIN_W      = $clog2(BINS);
  localparam int ADDR_W     = 2 * BIN_W;
  localparam int COUNT_BITS = 32;
  localparam int OUT_W      = 32;

  localparam logic [15:0] ENERGY_LOW_RST  = 16'd320;
  localparam logic [15:0] ENERGY_HIGH_RST = 16'd24000;
  localparam logic [15:0] TIME_LOW_RST    = 16'hD8F0;
  localparam logic [15:0] TIME_HIGH_RST   = 16'hFF6A;
  localparam logic [15:0] WINDOW_RST      = 16'd200;
  localparam logic [3:0]  SHIFT_RST       = 4'd4;
  localparam logic [11:0] BINS_USE_RST    = 12'd1500;

  typedef enum logic [2:0] {
    CFG_ENERGY_LOW  = 3'd0,
    CFG_ENERGY_HIGH = 3'd1,
    CFG_TIME_LOW    = 3'd2,
    CFG_TIME_HIGH   = 3'd3,
    CFG_WINDOW      = 3'd4,
    CFG_BIN_SHIFT   = 3'd5,
    CFG_BINS_IN_USE = 3'd6,
    CFG_UNUSED      = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_HIT   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SCAN,
    ST_BRD,
    ST_BWR,
    ST_STORE,
    ST_RD,
    ST_ROUT
  } state_t;

  typedef struct packed {
    logic        [15:0] energy;
    logic signed [15:0] hit_time;
  } hit_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic [ADDR_W-1:0]     raddr;
  } mem_ctl_t;

endpackage

FILE: rtl/core/gcm_cell.sv
// One kept-hit cell of the rotating hit ring.
module gcm_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  logic          load_en,
  input  gcm_pkg::hit_t load_d,
  input  gcm_pkg::hit_t next_d,
  output gcm_pkg::hit_t q
);

  gcm_pkg::hit_t q_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      q_r <= load_d;
    end else if (shift_en) begin
      q_r <= next_d;
    end
  end

  assign q = q_r;

endmodule

FILE: rtl/core/gcm_hist_ram.sv
// Histogram memory: one write port, one registered read port.
module gcm_hist_ram (
  input  logic                           clk,
  input  gcm_pkg::mem_ctl_t              ctl,
  output logic [gcm_pkg::COUNT_BITS-1:0] rdata
);

  logic [gcm_pkg::COUNT_BITS-1:0] mem [2**gcm_pkg::ADDR_W];
  logic [gcm_pkg::COUNT_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[ctl.raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/gamma_coincidence_matrix_unit.sv
// Top level: gamma coincidence matrix with a rotating ring of kept-hit cells.
//
// channel | handshake           | payload
// in      | in_valid/in_ready   | in_req_type in_energy in_hit_time in_event_end in_bin_x in_bin_y
// out     | out_valid/out_ready | out_bin_count
// cfg     | cfg_valid/cfg_ready | cfg_index cfg_data
//
// A kept hit rotates the ring of MAX_HITS cells once; each coincident pair adds
// ST_BRD and ST_BWR for bin (x,y) and again for (y,x), and ST_STORE then loads the hit.
// A read passes through ST_RD and ST_ROUT; a clear or a rejected hit is taken in ST_IDLE.
// After reset a clearing pass over all 2^22 addresses zeroes the histogram; in_ready low.
// A waiting result holds a following read request in ST_ROUT, with in_ready low meanwhile.
module gamma_coincidence_matrix_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_energy,
  input  logic signed [15:0] in_hit_time,
  input  logic        in_event_end,
  input  logic [10:0] in_bin_x,
  input  logic [10:0] in_bin_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_bin_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int MH  = gcm_pkg::MAX_HITS;
  localparam int IW  = gcm_pkg::HIT_IDX_W;
  localparam int KW  = gcm_pkg::KEPT_CNT_W;
  localparam int BW  = gcm_pkg::BIN_W;
  localparam int AW  = gcm_pkg::ADDR_W;
  localparam int CB  = gcm_pkg::COUNT_BITS;

  logic [15:0]        e_lo_r, e_hi_r, win_r;
  logic signed [15:0] t_lo_r, t_hi_r;
  logic [3:0]         shift_r;
  logic [11:0]        bins_use_r;

  gcm_pkg::state_t    state_r, state_nxt;
  logic [KW-1:0]      cnt_r;
  logic [IW-1:0]      step_r;
  logic               pass_r;
  logic [AW-1:0]      clr_addr_r;
  gcm_pkg::hit_t      hit_r;
  logic               last_r;
  logic [AW-1:0]      rq_addr_r;
  logic [BW-1:0]      px_r, py_r;
  logic               out_valid_r;
  logic [31:0]        out_count_r;

  gcm_pkg::hit_t      cell_q [MH];
  gcm_pkg::mem_ctl_t  mem_ctl;
  logic [CB-1:0]      rdata;
  logic               rotate, store_en, out_load;

  logic               accept, keep, room, pair_ok, step_last;
  logic signed [16:0] dt;
  logic [16:0]        adt;
  logic [15:0]        x_full, y_full;
  logic [11:0]        limit;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == gcm_pkg::ST_IDLE);
  assign keep      = (in_energy >= e_lo_r) && (in_energy <= e_hi_r) &&
                     (in_hit_time >= t_lo_r) && (in_hit_time <= t_hi_r);
  assign room      = (cnt_r < KW'(MH));
  assign step_last = (step_r == IW'(MH - 1));

  assign dt     = {hit_r.hit_time[15], hit_r.hit_time} -
                  {cell_q[0].hit_time[15], cell_q[0].hit_time};
  assign adt    = dt[16] ? 17'(-dt) : 17'(dt);
  assign x_full = hit_r.energy >> shift_r;
  assign y_full = cell_q[0].energy >> shift_r;
  assign limit  = (bins_use_r > 12'(gcm_pkg::BINS)) ? 12'(gcm_pkg::BINS) : bins_use_r;
  assign pair_ok = ({1'b0, step_r} < cnt_r) && (adt <= {1'b0, win_r}) &&
                   (x_full < {4'b0, limit}) && (y_full < {4'b0, limit});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_lo_r     <= gcm_pkg::ENERGY_LOW_RST;
      e_hi_r     <= gcm_pkg::ENERGY_HIGH_RST;
      t_lo_r     <= gcm_pkg::TIME_LOW_RST;
      t_hi_r     <= gcm_pkg::TIME_HIGH_RST;
      win_r      <= gcm_pkg::WINDOW_RST;
      shift_r    <= gcm_pkg::SHIFT_RST;
      bins_use_r <= gcm_pkg::BINS_USE_RST;
    end else if (cfg_valid) begin
      case (gcm_pkg::cfg_idx_t'(cfg_index))
        gcm_pkg::CFG_ENERGY_LOW:  e_lo_r     <= cfg_data;
        gcm_pkg::CFG_ENERGY_HIGH: e_hi_r     <= cfg_data;
        gcm_pkg::CFG_TIME_LOW:    t_lo_r     <= cfg_data;
        gcm_pkg::CFG_TIME_HIGH:   t_hi_r     <= cfg_data;
        gcm_pkg::CFG_WINDOW:      win_r      <= cfg_data;
        gcm_pkg::CFG_BIN_SHIFT:   shift_r    <= cfg_data[3:0];
        gcm_pkg::CFG_BINS_IN_USE: bins_use_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gcm_pkg::ST_CLR: begin
        if (&clr_addr_r) state_nxt = gcm_pkg::ST_IDLE;
      end
      gcm_pkg::ST_IDLE: begin
        if (accept) begin
          case (gcm_pkg::req_t'(in_req_type))
            gcm_pkg::REQ_HIT:  if (keep && room) state_nxt = gcm_pkg::ST_SCAN;
            gcm_pkg::REQ_READ: state_nxt = gcm_pkg::ST_RD;
            default: ;
          endcase
        end
      end
      gcm_pkg::ST_SCAN: begin
        if (pair_ok) state_nxt = gcm_pkg::ST_BRD;
        else if (step_last) state_nxt = gcm_pkg::ST_STORE;
      end
      gcm_pkg::ST_BRD: state_nxt = gcm_pkg::ST_BWR;
      gcm_pkg::ST_BWR: begin
        if (!pass_r) state_nxt = gcm_pkg::ST_BRD;
        else if (step_last) state_nxt = gcm_pkg::ST_STORE;
        else state_nxt = gcm_pkg::ST_SCAN;
      end
      gcm_pkg::ST_STORE: state_nxt = gcm_pkg::ST_IDLE;
      gcm_pkg::ST_RD:    state_nxt = gcm_pkg::ST_ROUT;
      gcm_pkg::ST_ROUT: begin
        if (!out_valid_r || out_ready) state_nxt = gcm_pkg::ST_IDLE;
      end
      default: state_nxt = gcm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    mem_ctl.we    = 1'b0;
    mem_ctl.waddr = rq_addr_r;
    mem_ctl.wdata = '0;
    mem_ctl.raddr = rq_addr_r;
    rotate        = 1'b0;
    store_en      = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      gcm_pkg::ST_CLR: begin
        mem_ctl.we    = 1'b1;
        mem_ctl.waddr = clr_addr_r;
      end
      gcm_pkg::ST_IDLE: begin
        if (accept && (gcm_pkg::req_t'(in_req_type) == gcm_pkg::REQ_CLEAR)) begin
          mem_ctl.we    = 1'b1;
          mem_ctl.waddr = {in_bin_x, in_bin_y};
        end
      end
      gcm_pkg::ST_SCAN: rotate = !pair_ok;
      gcm_pkg::ST_BRD:  mem_ctl.raddr = pass_r ? {py_r, px_r} : {px_r, py_r};
      gcm_pkg::ST_BWR: begin
        mem_ctl.we    = 1'b1;
        mem_ctl.waddr = pass_r ? {py_r, px_r} : {px_r, py_r};
        mem_ctl.wdata = (&rdata) ? rdata : rdata + CB'(1);
        rotate        = pass_r;
      end
      gcm_pkg::ST_STORE: store_en = 1'b1;
      gcm_pkg::ST_ROUT:  out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcm_pkg::ST_CLR;
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == gcm_pkg::ST_CLR) clr_addr_r <= clr_addr_r + AW'(1);
      if (accept && (gcm_pkg::req_t'(in_req_type) == gcm_pkg::REQ_HIT)) begin
        step_r <= '0;
        if (!(keep && room) && in_event_end) cnt_r <= '0;
      end
      if (rotate) step_r <= step_r + IW'(1);
      if (store_en) cnt_r <= last_r ? '0 : cnt_r + KW'(1);
      if (state_r == gcm_pkg::ST_SCAN) pass_r <= 1'b0;
      else if (state_r == gcm_pkg::ST_BWR) pass_r <= !pass_r;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r     <= '{energy: in_energy, hit_time: in_hit_time};
      last_r    <= in_event_end;
      rq_addr_r <= {in_bin_x, in_bin_y};
    end
    if (state_r == gcm_pkg::ST_SCAN) begin
      px_r <= x_full[BW-1:0];
      py_r <= y_full[BW-1:0];
    end
    if (out_load) out_count_r <= 32'(rdata);
  end

  genvar gi;
  generate
    for (gi = 0; gi < MH; gi++) begin : g_cell
      gcm_cell u_cell (
        .clk      (clk),
        .shift_en (rotate),
        .load_en  (store_en && (cnt_r[IW-1:0] == IW'(gi))),
        .load_d   (hit_r),
        .next_d   (cell_q[(gi + 1) % MH]),
        .q        (cell_q[gi])
      );
    end
  endgenerate

  gcm_hist_ram u_ram (
    .clk   (clk),
    .ctl   (mem_ctl),
    .rdata (rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_bin_count = out_count_r;

  a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gcm_pkg::ST_CLR) |-> !in_ready)
    else $error("input taken during clearing pass");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= KW'(MH))
    else $error("kept count beyond ring depth");

  a_scan_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gcm_pkg::ST_SCAN) |-> room)
    else $error("scan with full ring");

  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == gcm_pkg::REQ_READ) |=> (state_r == gcm_pkg::ST_RD))
    else $error("read request lost");

endmodule

FILE: bench/gcm_checker.sv
// Checker: watches the channels of the coincidence matrix unit, predicts read counts and compares.
module gcm_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [15:0]        in_energy,
  input  logic signed [15:0] in_hit_time,
  input  logic               in_event_end,
  input  logic [10:0]        in_bin_x,
  input  logic [10:0]        in_bin_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [31:0]        out_bin_count,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 errors,
  output int                 pending,
  output int                 reads_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0]        gate_e_lo, gate_e_hi, window;
  logic signed [15:0] gate_t_lo, gate_t_hi;
  logic [3:0]         shift;
  logic [11:0]        bins_used;

  gcm_pkg::hit_t      held_hits [gcm_pkg::MAX_HITS];
  int                 held_cnt;
  logic [31:0]        matrix [int unsigned];
  logic [31:0]        count_fifo [$];

  function automatic logic [31:0] bin_value(input int unsigned x, input int unsigned y);
    int unsigned a;
    a = x * gcm_pkg::BINS + y;
    return matrix.exists(a) ? matrix[a] : 32'd0;
  endfunction

  task automatic bump_bin(input int unsigned x, input int unsigned y);
    logic [31:0] c;
    c = bin_value(x, y);
    if (c != 32'hFFFF_FFFF) matrix[x * gcm_pkg::BINS + y] = c + 32'd1;
  endtask

  task automatic fill_pair(input logic [15:0] ea, input logic [15:0] eb);
    int unsigned lim, x, y;
    lim = (bins_used < gcm_pkg::BINS) ? bins_used : gcm_pkg::BINS;
    x = ea >> shift;
    y = eb >> shift;
    if (x < lim && y < lim) begin
      bump_bin(x, y);
      bump_bin(y, x);
    end
  endtask

  task automatic take_item();
    int d;
    bit keep;
    case (gcm_pkg::req_t'(in_req_type))
      gcm_pkg::REQ_HIT: begin
        keep = in_energy >= gate_e_lo && in_energy <= gate_e_hi &&
               in_hit_time >= gate_t_lo && in_hit_time <= gate_t_hi;
        if (keep && held_cnt < gcm_pkg::MAX_HITS) begin
          for (int i = 0; i < held_cnt; i++) begin
            d = int'(in_hit_time) - int'(held_hits[i].hit_time);
            if (d < 0) d = -d;
            if (d <= int'(window)) fill_pair(in_energy, held_hits[i].energy);
          end
          held_hits[held_cnt] = '{energy: in_energy, hit_time: in_hit_time};
          held_cnt++;
        end
        if (in_event_end) held_cnt = 0;
      end
      gcm_pkg::REQ_READ:  count_fifo.push_back(bin_value(in_bin_x, in_bin_y));
      gcm_pkg::REQ_CLEAR: matrix.delete(int'(in_bin_x) * gcm_pkg::BINS + int'(in_bin_y));
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gate_e_lo = gcm_pkg::ENERGY_LOW_RST;
      gate_e_hi = gcm_pkg::ENERGY_HIGH_RST;
      gate_t_lo = gcm_pkg::TIME_LOW_RST;
      gate_t_hi = gcm_pkg::TIME_HIGH_RST;
      window    = gcm_pkg::WINDOW_RST;
      shift     = gcm_pkg::SHIFT_RST;
      bins_used = gcm_pkg::BINS_USE_RST;
      held_cnt  = 0;
      matrix.delete();
      count_fifo.delete();
      errors     = 0;
      reads_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (gcm_pkg::cfg_idx_t'(cfg_index))
          gcm_pkg::CFG_ENERGY_LOW:  gate_e_lo = cfg_data;
          gcm_pkg::CFG_ENERGY_HIGH: gate_e_hi = cfg_data;
          gcm_pkg::CFG_TIME_LOW:    gate_t_lo = cfg_data;
          gcm_pkg::CFG_TIME_HIGH:   gate_t_hi = cfg_data;
          gcm_pkg::CFG_WINDOW:      window    = cfg_data;
          gcm_pkg::CFG_BIN_SHIFT:   shift     = cfg_data[3:0];
          gcm_pkg::CFG_BINS_IN_USE: bins_used = cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_item();
      if (out_valid && out_ready) begin
        reads_seen++;
        if (count_fifo.size() == 0) begin
          $error("unexpected item: bin_count actual %0d", out_bin_count);
          errors++;
        end else begin
          if (out_bin_count !== count_fifo[0]) begin
            $error("bin_count mismatch: expected %0d actual %0d", count_fifo[0], out_bin_count);
            errors++;
          end
          void'(count_fifo.pop_front());
        end
      end
    end
    pending = count_fifo.size();
  end
endmodule

FILE: bench/gamma_coincidence_matrix_unit_tb.sv
// Testbench top: drives hits, bin reads, clears and register writes into the matrix unit.
module gamma_coincidence_matrix_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 30_000_000;
  localparam int DRAIN = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_req_type = gcm_pkg::REQ_NONE;
  logic [15:0]        in_energy = '0;
  logic signed [15:0] in_hit_time = '0;
  logic               in_event_end = 1'b0;
  logic [10:0]        in_bin_x = '0;
  logic [10:0]        in_bin_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic [31:0]        out_bin_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = gcm_pkg::CFG_UNUSED;
  logic [15:0]        cfg_data = '0;

  int errors, pending, reads_seen;
  int cycles = 0;
  int idle_pct = 0, stall_pct = 0;
  int items_sent = 0;
  int e_lo = 320, e_hi = 24000, t_lo = -10000, t_hi = -150, win = 200, cur_shift = 4;
  logic [10:0] seen_bins [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gamma_coincidence_matrix_unit dut (.*);

  gcm_checker checker_i (.*);

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(input gcm_pkg::req_t r, input logic [15:0] e,
                      input logic signed [15:0] t,
                      input logic last, input logic [10:0] bx, input logic [10:0] by);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= r;
    in_energy    <= e;
    in_hit_time  <= t;
    in_event_end <= last;
    in_bin_x     <= bx;
    in_bin_y     <= by;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (r == gcm_pkg::REQ_HIT) begin
      seen_bins.push_back(11'(e >> cur_shift));
      if (seen_bins.size() > 16) void'(seen_bins.pop_front());
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input gcm_pkg::cfg_idx_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      gcm_pkg::CFG_ENERGY_LOW:  e_lo = val;
      gcm_pkg::CFG_ENERGY_HIGH: e_hi = val;
      gcm_pkg::CFG_TIME_LOW:    t_lo = val;
      gcm_pkg::CFG_TIME_HIGH:   t_hi = val;
      gcm_pkg::CFG_WINDOW:      win = val;
      gcm_pkg::CFG_BIN_SHIFT:   cur_shift = val;
      default: ;
    endcase
  endtask

  task automatic set_gates(input int elo, input int ehi, input int tlo, input int thi,
                           input int w, input int sh, input int used);
    settle();
    write_reg(gcm_pkg::CFG_ENERGY_LOW, elo);
    write_reg(gcm_pkg::CFG_ENERGY_HIGH, ehi);
    write_reg(gcm_pkg::CFG_TIME_LOW, tlo);
    write_reg(gcm_pkg::CFG_TIME_HIGH, thi);
    write_reg(gcm_pkg::CFG_WINDOW, w);
    write_reg(gcm_pkg::CFG_BIN_SHIFT, sh);
    write_reg(gcm_pkg::CFG_BINS_IN_USE, used);
  endtask

  function automatic logic [10:0] pick_bin();
    if (seen_bins.size() > 0 && $urandom_range(9) < 7)
      return seen_bins[$urandom_range(seen_bins.size() - 1)];
    return 11'($urandom);
  endfunction

  task automatic send_hit(input int tbase, input logic last);
    int e, t, spread;
    if ($urandom_range(9) == 0 || e_lo > e_hi) e = $urandom_range(65535);
    else e = $urandom_range(e_hi, e_lo);
    spread = (win > 300) ? 300 : win + 2;
    t = tbase + $urandom_range(2 * spread) - spread;
    if ($urandom_range(9) == 0) t = $urandom_range(65535) - 32768;
    else if (t_lo <= t_hi) t = (t < t_lo) ? t_lo : (t > t_hi) ? t_hi : t;
    send(gcm_pkg::REQ_HIT, 16'(e), 16'(t), last, 11'($urandom), 11'($urandom));
  endtask

  task automatic run_mix(input int n);
    int start, len, base, mode, pick;
    int idle_tab [4] = '{0, 59, 0, 17};
    int stall_tab [4] = '{0, 0, 59, 17};
    start = items_sent;
    mode = 0;
    while (items_sent - start < n) begin
      if ((items_sent - start) / 40 % 4 != mode) begin
        mode = (items_sent - start) / 40 % 4;
        idle_pct  = idle_tab[mode];
        stall_pct = stall_tab[mode];
      end
      pick = $urandom_range(99);
      if (pick < 65) begin
        len = $urandom_range(1, 6);
        base = (t_lo <= t_hi) ? $urandom_range(t_hi + 32768, t_lo + 32768) - 32768 : 0;
        for (int i = 0; i < len; i++) send_hit(base, i == len - 1);
      end else if (pick < 85) begin
        send(gcm_pkg::REQ_READ, 16'($urandom), 16'($urandom), 1'($urandom),
             pick_bin(), pick_bin());
      end else if (pick < 92) begin
        send(gcm_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom),
             pick_bin(), pick_bin());
      end else if (pick < 96) begin
        send(gcm_pkg::REQ_NONE, 16'($urandom), 16'($urandom), 1'($urandom),
             11'($urandom), 11'($urandom));
      end else begin
        send(gcm_pkg::REQ_HIT, 16'($urandom), 16'($urandom), 1'($urandom),
             11'($urandom), 11'($urandom));
      end
    end
    idle_pct = 0;
    stall_pct = 0;
    send(gcm_pkg::REQ_HIT, 16'd0, 16'sd0, 1'b1, 11'd0, 11'd0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send(gcm_pkg::REQ_READ, 16'd0, 16'sd0, 1'b0, 11'd0, 11'd0);
    send(gcm_pkg::REQ_READ, 16'hFFFF, -16'sd1, 1'b1, 11'h7FF, 11'h7FF);
    send(gcm_pkg::REQ_CLEAR, 16'd0, 16'sd0, 1'b0, 11'h7FF, 11'd0);
    send(gcm_pkg::REQ_NONE, 16'hFFFF, -16'sd1, 1'b1, 11'h7FF, 11'h7FF);
    send(gcm_pkg::REQ_HIT, 16'd320, -16'sd10000, 1'b0, 11'd0, 11'd0);
    send(gcm_pkg::REQ_HIT, 16'd24000, -16'sd150, 1'b0, 11'd0, 11'd0);
    send(gcm_pkg::REQ_HIT, 16'd319, -16'sd160, 1'b0, 11'd0, 11'd0);
    send(gcm_pkg::REQ_HIT, 16'd24001, -16'sd160, 1'b0, 11'd0, 11'd0);
    send(gcm_pkg::REQ_HIT, 16'd1000, -16'sd10001, 1'b0, 11'd0, 11'd0);
    send(gcm_pkg::REQ_HIT, 16'd1000, -16'sd149, 1'b1, 11'd0, 11'd0);
    send(gcm_pkg::REQ_HIT, 16'd1000, -16'sd1000, 1'b0, 11'd0, 11'd0);
    send(gcm_pkg::REQ_HIT, 16'd1000, -16'sd900, 1'b0, 11'd0, 11'd0);
    send(gcm_pkg::REQ_HIT, 16'd23999, -16'sd1100, 1'b0, 11'd0, 11'd0);
    send(gcm_pkg::REQ_HIT, 16'd2000, -16'sd1301, 1'b0, 11'd0, 11'd0);
    send(gcm_pkg::REQ_HIT, 16'd65535, -16'sd1000, 1'b0, 11'd0, 11'd0);
    send(gcm_pkg::REQ_HIT, 16'd0, -16'sd32768, 1'b1, 11'd0, 11'd0);
    send(gcm_pkg::REQ_HIT, 16'd3000, -16'sd1000, 1'b1, 11'd0, 11'd0);
    send(gcm_pkg::REQ_READ, 16'd0, 16'sd0, 1'b0, 11'd62, 11'd62);
    send(gcm_pkg::REQ_READ, 16'd0, 16'sd0, 1'b0, 11'd1499, 11'd62);
    send(gcm_pkg::REQ_READ, 16'd0, 16'sd0, 1'b0, 11'd62, 11'd1499);
    send(gcm_pkg::REQ_READ, 16'd0, 16'sd0, 1'b0, 11'd187, 11'd62);
    send(gcm_pkg::REQ_CLEAR, 16'd0, 16'sd0, 1'b0, 11'd62, 11'd62);
    send(gcm_pkg::REQ_READ, 16'd0, 16'sd0, 1'b0, 11'd62, 11'd62);
    send(gcm_pkg::REQ_READ, 16'd0, 16'sd0, 1'b0, 11'd1499, 11'd62);
    send(gcm_pkg::REQ_HIT, 16'd0, 16'sd0, 1'b1, 11'd0, 11'd0);

    run_mix(200);

    set_gates(0, 65535, -32768, 32767, 65535, 15, 4095);
    write_reg(gcm_pkg::CFG_UNUSED, 16'hFFFF);
    for (int i = 0; i < 66; i++)
      send(gcm_pkg::REQ_HIT, 16'($urandom), 16'($urandom), i == 65, 11'd0, 11'd0);
    send(gcm_pkg::REQ_READ, 16'd0, 16'sd0, 1'b0, 11'd0, 11'd1);
    send(gcm_pkg::REQ_READ, 16'd0, 16'sd0, 1'b0, 11'd1, 11'd1);
    run_mix(150);

    set_gates(0, 50, -32768, 32767, 1000, 0, 1);
    run_mix(150);

    set_gates(0, 65535, -2000, 2000, 0, 8, 0);
    run_mix(150);

    set_gates(1000, 999, 100, -100, 200, 4, 2048);
    run_mix(100);

    set_gates(0, 65535, -500, 500, 100, 6, 2048);
    run_mix(300);

    set_gates(4000, 8000, -300, 300, 50, 3, 1200);
    run_mix(150);

    settle();
    $display("Covered %0d items over seven register settings, %0d bin reads compared.",
             items_sent, reads_seen);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
